// File: src/pbs_pkg.sv
package pbs_pkg;

    localparam int PIX_W      = 16;
    localparam int LW_W       = 13;
    localparam int SHIFT_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SHIFT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'd1;

    // bin_shift codes
    localparam logic [SHIFT_W-1:0] BIN_COPY = 2'd0;
    localparam logic [SHIFT_W-1:0] BIN_2X2  = 2'd1;
    localparam logic [SHIFT_W-1:0] BIN_4X4  = 2'd2;

    localparam logic [SHIFT_W-1:0] BIN_SHIFT_RESET  = BIN_2X2;
    localparam logic [LW_W-1:0]    LINE_WIDTH_RESET = 13'd4096;

    // result queue
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 2;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix pix;
        logic row_last;
    } t_out;

    function automatic t_pix sat_add(input t_pix a, input t_pix b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W] ? {PIX_W{1'b1}} : s[PIX_W-1:0];
    endfunction

endpackage

// File: src/pbs_out_fifo.sv
module pbs_out_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  pbs_pkg::t_out                    i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output pbs_pkg::t_out                    o_data,
    output logic [pbs_pkg::OUT_CNT_W-1:0]    o_count
);
    import pbs_pkg::*;

    t_out                 r_entry [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    function automatic logic [OUT_PTR_W-1:0] ptr_inc(input logic [OUT_PTR_W-1:0] p);
        return (p == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : p + OUT_PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= r_count + OUT_CNT_W'(i_push) - OUT_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: src/pixel_binning_saturating_core.sv
// a result passes the second stage and then the result queue before it is offered
// throughput: 1 pixel per cycle while o_in_stall is low, set by the single
// read-modify-write pass on the line store
// a 3-entry result queue lets input keep flowing while a result waits on the output
// reset (synchronous, active low) clears counters, row accumulator and queue, and loads
// bin_shift = 1 and line_width = 4096; the line store is not cleared and needs no pass
module pixel_binning_saturating_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pbs_pkg::PIX_W-1:0]          i_pixel,
    input  logic                               i_frame_start,
    // binned output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pbs_pkg::PIX_W-1:0]          o_binned_pixel,
    output logic                               o_row_last,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pbs_pkg::*;

    // line store holds one partial column sum per output column
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = $clog2(DEPTH);
    // column counter range 0 .. MAX_WIDTH-1
    localparam int CW    = $clog2(MAX_WIDTH);
    // width for line length compares, covers both the register and MAX_WIDTH
    localparam int WW    = ($clog2(MAX_WIDTH + 1) > LW_W) ? $clog2(MAX_WIDTH + 1) : LW_W;

    // configuration registers
    logic [SHIFT_W-1:0] r_bin_shift;
    logic [LW_W-1:0]    r_line_width;

    // raster position and row accumulator
    logic [CW-1:0]      r_col;
    logic [1:0]         r_phase;
    t_pix               r_acc;

    // second stage: line store read data plus the closed square
    t_pix               r_rd_data;
    logic               r_s1_emit;
    logic               r_s1_wr;
    logic               r_s1_prev;
    t_pix               r_s1_val;
    logic               r_s1_last;
    logic [AW-1:0]      r_s1_addr;

    t_pix               column_sums [DEPTH];

    logic               take;
    logic [SHIFT_W-1:0] shift;
    logic [WW-1:0]      lw_ext;
    logic [WW-1:0]      w_lim;
    logic [CW-1:0]      col;
    logic [1:0]         phase;
    t_pix               acc_base;
    t_pix               acc_new;
    logic               line_end;
    logic [1:0]         f_m1;
    logic [1:0]         sub;
    logic [CW-1:0]      oc;
    logic               close_sq;
    logic               last_row;
    logic               in_range;
    logic               row_last_sq;
    logic               emit0;
    t_pix               sum;
    t_out               out_data;
    t_out               q_data;
    logic [OUT_CNT_W-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    // writes land at once; the user must use the port only while the block is idle, unchecked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_shift  <= BIN_SHIFT_RESET;
            r_line_width <= LINE_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_BIN_SHIFT) begin
                r_bin_shift <= i_cfg_data[SHIFT_W-1:0];
            end else begin
                r_line_width <= i_cfg_data[LW_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // first stage: position bookkeeping, row accumulate, store read
    // ---------------------------------------------------------------
    always_comb begin
        // shift code three behaves as four by four
        shift = (r_bin_shift > BIN_4X4) ? BIN_4X4 : r_bin_shift;

        // clamp the line width into 1 .. MAX_WIDTH
        lw_ext = WW'(r_line_width);
        if (r_line_width == '0) begin
            w_lim = WW'(1);
        end else if (lw_ext > WW'(MAX_WIDTH)) begin
            w_lim = WW'(MAX_WIDTH);
        end else begin
            w_lim = lw_ext;
        end

        // frame start restarts the raster before this pixel is taken
        col      = i_frame_start ? '0 : r_col;
        phase    = i_frame_start ? '0 : r_phase;
        acc_base = i_frame_start ? '0 : r_acc;

        // a counter past the end (after a width change) also ends the line
        line_end = (WW'(col) + WW'(1)) >= w_lim;

        unique case (shift)
            BIN_4X4: f_m1 = 2'd3;
            BIN_2X2: f_m1 = 2'd1;
            default: f_m1 = 2'd0;
        endcase

        sub      = col[1:0] & f_m1;
        oc       = col >> shift;
        acc_new  = sat_add((sub == 2'd0) ? t_pix'(0) : acc_base, i_pixel);
        close_sq = (shift != BIN_COPY) && (sub == f_m1);
        last_row = (phase >= f_m1);
        in_range = (oc < CW'(DEPTH));

        row_last_sq = (WW'(oc) + WW'(1)) == (w_lim >> shift);
        emit0       = (shift == BIN_COPY) || (close_sq && last_row);
    end

    assign take = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_phase   <= '0;
            r_acc     <= '0;
            r_s1_emit <= 1'b0;
            r_s1_wr   <= 1'b0;
        end else begin
            r_s1_emit <= take && emit0;
            // every row of a band but the last parks the partial sum in the store
            r_s1_wr   <= take && close_sq && !last_row && in_range;
            if (take) begin
                r_acc <= (shift == BIN_COPY) ? acc_base : acc_new;
                if (line_end) begin
                    r_col   <= '0;
                    r_phase <= last_row ? 2'd0 : phase + 2'd1;
                end else begin
                    r_col   <= col + CW'(1);
                    r_phase <= phase;
                end
            end
        end
    end

    // payload of the second stage
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_prev <= close_sq && (phase != 2'd0) && in_range;
            r_s1_val  <= (shift == BIN_COPY) ? i_pixel : acc_new;
            r_s1_last <= (shift == BIN_COPY) ? line_end : row_last_sq;
            r_s1_addr <= oc[AW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // line store: read on transfer, write back in the cycle after
    // two squares never close back to back, so a read whose data is used never
    // meets a pending write to the same column
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_data <= column_sums[oc[AW-1:0]];
        end
        if (r_s1_wr) begin
            column_sums[r_s1_addr] <= sum;
        end
    end

    // ---------------------------------------------------------------
    // second stage: add the stored column sum, then store or emit
    // ---------------------------------------------------------------
    assign sum = r_s1_prev ? sat_add(r_rd_data, r_s1_val) : r_s1_val;

    always_comb begin
        out_data.pix      = sum;
        out_data.row_last = r_s1_last;
    end

    pbs_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_emit),
        .i_data  (out_data),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_binned_pixel = q_data.pix;
    assign o_row_last     = q_data.row_last;

    // hold off input while queued plus in-flight results could overrun the queue
    assign o_in_stall = ({1'b0, q_count} + {{OUT_CNT_W{1'b0}}, r_s1_emit})
                        >= (OUT_CNT_W + 1)'(OUT_DEPTH);

endmodule
